FILE: src/stepper_phase_sequencer_core_assert.svh
// ----------------------------------------------------------------------------
// Stepper phase sequencer assertion macros
// Shared concurrent assertion forms, clocked on clk and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef STEPPER_PHASE_SEQUENCER_CORE_ASSERT_SVH
`define STEPPER_PHASE_SEQUENCER_CORE_ASSERT_SVH

// same-cycle implication
`define SPS_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("sps assertion failed");

// next-cycle implication
`define SPS_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("sps assertion failed");

`endif

FILE: src/sps_pkg.sv
// ----------------------------------------------------------------------------
// Stepper phase sequencer package
// Widths, codes, transaction types and the half-step coil table.
// ----------------------------------------------------------------------------
`default_nettype none

package sps_pkg;

  localparam int COUNT_BITS    = 16;
  localparam int POSITION_BITS = 32;
  localparam int PHASE_BITS    = 3;
  localparam int PADDR_BITS    = 3;

  typedef enum logic {
    OP_TICK = 1'b0,
    OP_MOVE = 1'b1
  } opcode_t;

  typedef enum logic {
    TRAVEL_RIGHT = 1'b0,
    TRAVEL_LEFT  = 1'b1
  } dir_t;

  localparam logic [PADDR_BITS-3:0] REG_HOMED = '0;

  typedef struct packed {
    opcode_t     opcode;
    dir_t        direction;
    logic [1:0]  stride;
    logic [15:0] move_count;
    logic        user_request;
    logic        right_limit;
    logic        left_limit;
  } cmd_t;

  typedef struct packed {
    logic [3:0]         coil_pattern;
    logic               coil_update;
    logic signed [31:0] position;
    logic               busy_res;
    logic               limit_stop;
    logic               command_taken;
  } res_t;

  function automatic logic [3:0] coil_lookup(input logic [PHASE_BITS-1:0] ph);
    logic [3:0] pat;
    unique case (ph)
      3'd0:    pat = 4'h8;
      3'd1:    pat = 4'hA;
      3'd2:    pat = 4'h2;
      3'd3:    pat = 4'h6;
      3'd4:    pat = 4'h4;
      3'd5:    pat = 4'h5;
      3'd6:    pat = 4'h1;
      default: pat = 4'h9;
    endcase
    return pat;
  endfunction

endpackage

`default_nettype wire

FILE: src/sps_if.sv
// ----------------------------------------------------------------------------
// Stepper phase sequencer channels
// Valid/ready command and result channels with their payload fields.
// ----------------------------------------------------------------------------
`default_nettype none

interface sps_cmd_if;
  logic        valid;
  logic        ready;
  logic        opcode;
  logic        direction;
  logic [1:0]  stride;
  logic [15:0] move_count;
  logic        user_request;
  logic        right_limit;
  logic        left_limit;

  modport source (
    output valid, opcode, direction, stride, move_count, user_request,
           right_limit, left_limit,
    input  ready
  );
  modport sink (
    input  valid, opcode, direction, stride, move_count, user_request,
           right_limit, left_limit,
    output ready
  );
endinterface

interface sps_res_if;
  logic               valid;
  logic               ready;
  logic [3:0]         coil_pattern;
  logic               coil_update;
  logic signed [31:0] position;
  logic               busy_res;
  logic               limit_stop;
  logic               command_taken;

  modport source (
    output valid, coil_pattern, coil_update, position, busy_res, limit_stop,
           command_taken,
    input  ready
  );
  modport sink (
    input  valid, coil_pattern, coil_update, position, busy_res, limit_stop,
           command_taken,
    output ready
  );
endinterface

`default_nettype wire

FILE: src/stepper_phase_sequencer_core.sv
// A command transaction accepted into the input register passes through the step
// logic into the result register, which offers it as a result transaction.
// Throughput: one transaction per cycle; input register, step logic and result
// register advance together whenever the result register is empty or being taken.
// Reset (rst, synchronous): pipeline empties, phase and position clear, direction
// left, coils off, homed set to 1.
// ----------------------------------------------------------------------------
// Stepper phase sequencer core
// Half-step four-coil stepper sequencer with limit switches and APB config.
// ----------------------------------------------------------------------------
`default_nettype none

module stepper_phase_sequencer_core
  import sps_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  sps_cmd_if.sink               cmd,
  sps_res_if.source             res,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [PADDR_BITS-1:0] paddr,
  input  logic [31:0]           pwdata,
  output logic [31:0]           prdata,
  output logic                  pready
);

  logic homed;
  logic advance;
  logic q_valid;
  logic fire;
  cmd_t q;
  res_t result;

  assign fire = q_valid && advance;

  sps_apb_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .homed   (homed)
  );

  sps_in_reg u_in (
    .clk     (clk),
    .rst     (rst),
    .cmd     (cmd),
    .advance (advance),
    .q_valid (q_valid),
    .q       (q)
  );

  sps_step_logic u_step (
    .clk    (clk),
    .rst    (rst),
    .fire   (fire),
    .q      (q),
    .homed  (homed),
    .result (result)
  );

  sps_out_reg u_out (
    .clk     (clk),
    .rst     (rst),
    .fire    (fire),
    .result  (result),
    .advance (advance),
    .res     (res)
  );

endmodule

`default_nettype wire

FILE: src/sps_apb_regs.sv
// ----------------------------------------------------------------------------
// Stepper phase sequencer configuration registers
// APB write and read of the homed register.
// ----------------------------------------------------------------------------
`default_nettype none

module sps_apb_regs
  import sps_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [PADDR_BITS-1:0] paddr,
  input  logic [31:0]           pwdata,
  output logic [31:0]           prdata,
  output logic                  pready,
  output logic                  homed
);

  logic [PADDR_BITS-3:0] word_sel;

  assign word_sel = paddr[PADDR_BITS-1:2];
  assign pready   = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      homed <= 1'b1;
    end else if (psel && penable && pwrite && pready && word_sel == REG_HOMED) begin
      homed <= pwdata[0];
    end
  end

  always_comb begin
    prdata = '0;
    if (word_sel == REG_HOMED) begin
      prdata[0] = homed;
    end
  end

endmodule

`default_nettype wire

FILE: src/sps_in_reg.sv
// ----------------------------------------------------------------------------
// Stepper phase sequencer input register
// Capture one command transaction and hold it until the step stage takes it.
// ----------------------------------------------------------------------------
`default_nettype none

module sps_in_reg
  import sps_pkg::*;
(
  input  logic          clk,
  input  logic          rst,
  sps_cmd_if.sink       cmd,
  input  logic          advance,
  output logic          q_valid,
  output cmd_t          q
);

  assign cmd.ready = !q_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      q_valid <= 1'b0;
    end else if (cmd.ready) begin
      q_valid <= cmd.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.valid && cmd.ready) begin
      q.opcode       <= opcode_t'(cmd.opcode);
      q.direction    <= dir_t'(cmd.direction);
      q.stride       <= cmd.stride;
      q.move_count   <= cmd.move_count;
      q.user_request <= cmd.user_request;
      q.right_limit  <= cmd.right_limit;
      q.left_limit   <= cmd.left_limit;
    end
  end

endmodule

`default_nettype wire

FILE: src/sps_step_logic.sv
// ----------------------------------------------------------------------------
// Stepper phase sequencer step logic
// Motion state and its single-pass update for one tick or move command.
// ----------------------------------------------------------------------------
`default_nettype none

`include "stepper_phase_sequencer_core_assert.svh"

module sps_step_logic
  import sps_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic fire,
  input  cmd_t q,
  input  logic homed,
  output res_t result
);

  logic [PHASE_BITS-1:0]    phase, phase_next;
  dir_t                     move_left, move_left_next;
  logic [PHASE_BITS-1:0]    phase_delta, phase_delta_next;
  logic [COUNT_BITS-1:0]    steps_left, steps_left_next;
  logic [POSITION_BITS-1:0] step_position, step_position_next;
  logic [3:0]               coil_hold, coil_hold_next;
  logic                     upd, stop, taken;
  logic                     cmd_blocked, tick_blocked;
  logic [PHASE_BITS-1:0]    size_ext;

  assign size_ext     = PHASE_BITS'(q.stride);
  assign cmd_blocked  = (q.right_limit && q.direction == TRAVEL_RIGHT) ||
                        (q.left_limit && q.direction == TRAVEL_LEFT);
  assign tick_blocked = (q.right_limit && move_left == TRAVEL_RIGHT) ||
                        (q.left_limit && move_left == TRAVEL_LEFT);

  always_comb begin
    phase_next         = phase;
    move_left_next     = move_left;
    phase_delta_next   = phase_delta;
    steps_left_next    = steps_left;
    step_position_next = step_position;
    coil_hold_next     = coil_hold;
    upd                = 1'b0;
    stop               = 1'b0;
    taken              = 1'b0;
    unique case (q.opcode)
      OP_MOVE: begin
        if (!(q.user_request && !homed)) begin
          if (cmd_blocked) begin
            steps_left_next = '0;
            stop            = 1'b1;
          end else begin
            move_left_next   = q.direction;
            phase_delta_next = (q.direction == TRAVEL_LEFT) ? PHASE_BITS'(-size_ext)
                                                            : size_ext;
            steps_left_next  = COUNT_BITS'(q.move_count);
            taken            = 1'b1;
          end
        end
      end
      OP_TICK: begin
        if (steps_left != '0) begin
          if (tick_blocked) begin
            steps_left_next = '0;
            stop            = 1'b1;
          end else begin
            coil_hold_next  = coil_lookup(phase);
            upd             = 1'b1;
            phase_next      = phase + phase_delta;
            steps_left_next = steps_left - COUNT_BITS'(1);
            step_position_next = (move_left == TRAVEL_LEFT)
                                 ? step_position - POSITION_BITS'(1)
                                 : step_position + POSITION_BITS'(1);
          end
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase         <= '0;
      move_left     <= TRAVEL_LEFT;
      phase_delta   <= '0;
      steps_left    <= '0;
      step_position <= '0;
      coil_hold     <= '0;
    end else if (fire) begin
      phase         <= phase_next;
      move_left     <= move_left_next;
      phase_delta   <= phase_delta_next;
      steps_left    <= steps_left_next;
      step_position <= step_position_next;
      coil_hold     <= coil_hold_next;
    end
  end

  always_comb begin
    result.coil_pattern  = coil_hold_next;
    result.coil_update   = upd;
    result.position      = 32'(signed'(step_position_next));
    result.busy_res      = (steps_left_next != '0);
    result.limit_stop    = stop;
    result.command_taken = taken;
  end

  `SPS_ASSERT_NEXT(a_step_decrements, fire && upd,
                   steps_left == $past(steps_left) - COUNT_BITS'(1))
  `SPS_ASSERT_NEXT(a_stop_clears, fire && stop, steps_left == '0)
  `SPS_ASSERT_NOW(a_flags_exclusive, fire, !(upd && taken) && !(upd && stop))
  `SPS_ASSERT_NEXT(a_hold_when_idle, !fire, $stable(phase) && $stable(step_position))

endmodule

`default_nettype wire

FILE: src/sps_out_reg.sv
// ----------------------------------------------------------------------------
// Stepper phase sequencer result register
// Hold one result transaction until the sink takes it.
// ----------------------------------------------------------------------------
`default_nettype none

module sps_out_reg
  import sps_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  logic      fire,
  input  res_t      result,
  output logic      advance,
  sps_res_if.source res
);

  res_t hold;
  logic valid;

  assign advance = !valid || res.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (advance) begin
      valid <= fire;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      hold <= result;
    end
  end

  assign res.valid         = valid;
  assign res.coil_pattern  = hold.coil_pattern;
  assign res.coil_update   = hold.coil_update;
  assign res.position      = hold.position;
  assign res.busy_res      = hold.busy_res;
  assign res.limit_stop    = hold.limit_stop;
  assign res.command_taken = hold.command_taken;

endmodule

`default_nettype wire

FILE: verif/sps_motion_checker.sv
// ----------------------------------------------------------------------------
// Stepper phase sequencer motion checker
// Watches the command, result and config channels, tracks phase, coils,
// remaining steps and position per accepted transaction, and compares each
// accepted result field by field against the oldest predicted result.
// ----------------------------------------------------------------------------
`default_nettype none

module sps_motion_checker
  import sps_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  sps_cmd_if                    cmd,
  sps_res_if                    res,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [PADDR_BITS-1:0] paddr,
  input  logic [31:0]           pwdata,
  input  logic                  pready,
  output int                    errors,
  output int                    pending
);

  localparam logic [3:0] HALF_STEP_COILS [8] = '{
    4'h8, 4'hA, 4'h2, 4'h6, 4'h4, 4'h5, 4'h1, 4'h9
  };

  logic                  homed;
  logic [PHASE_BITS-1:0] phase;
  dir_t                  travel;
  logic [PHASE_BITS-1:0] phase_step;
  logic [15:0]           steps_left;
  logic [31:0]           position;
  logic [3:0]            coils;
  res_t                  motion_q[$];
  int                    fails = 0;
  int                    queued = 0;

  assign errors  = fails;
  assign pending = queued;

  task automatic advance_motor(input cmd_t c, output res_t r);
    logic blocked;
    r = '0;
    if (c.opcode == OP_MOVE) begin
      if (!(c.user_request && !homed)) begin
        blocked = (c.direction == TRAVEL_RIGHT) ? c.right_limit : c.left_limit;
        if (blocked) begin
          steps_left   = '0;
          r.limit_stop = 1'b1;
        end else begin
          travel          = c.direction;
          phase_step      = (c.direction == TRAVEL_LEFT) ? 3'(0 - c.stride)
                                                         : 3'(c.stride);
          steps_left      = c.move_count;
          r.command_taken = 1'b1;
        end
      end
    end else if (steps_left != 0) begin
      blocked = (travel == TRAVEL_RIGHT) ? c.right_limit : c.left_limit;
      if (blocked) begin
        steps_left   = '0;
        r.limit_stop = 1'b1;
      end else begin
        coils         = HALF_STEP_COILS[phase];
        r.coil_update = 1'b1;
        phase         = phase + phase_step;
        steps_left    = steps_left - 1'b1;
        position      = (travel == TRAVEL_LEFT) ? position - 1 : position + 1;
      end
    end
    r.coil_pattern = coils;
    r.position     = position;
    r.busy_res     = (steps_left != 0);
  endtask

  function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
    if (got !== want) begin
      $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
      fails++;
    end
  endfunction

  always @(posedge clk) begin : watch
    cmd_t c;
    res_t want;
    if (rst) begin
      homed      = 1'b1;
      phase      = '0;
      travel     = TRAVEL_LEFT;
      phase_step = '0;
      steps_left = '0;
      position   = '0;
      coils      = '0;
      motion_q.delete();
    end else begin
      if (psel && penable && pwrite && pready &&
          paddr[PADDR_BITS-1:2] == REG_HOMED && paddr[1:0] == 2'b00) begin
        homed = pwdata[0];
      end
      if (res.valid && res.ready) begin
        if (motion_q.size() == 0) begin
          $error("result transaction with no prediction pending");
          fails++;
        end else begin
          want = motion_q.pop_front();
          check_field("coil_pattern", 32'(want.coil_pattern), 32'(res.coil_pattern));
          check_field("coil_update", 32'(want.coil_update), 32'(res.coil_update));
          check_field("position", want.position, res.position);
          check_field("busy_res", 32'(want.busy_res), 32'(res.busy_res));
          check_field("limit_stop", 32'(want.limit_stop), 32'(res.limit_stop));
          check_field("command_taken", 32'(want.command_taken),
                      32'(res.command_taken));
        end
      end
      if (cmd.valid && cmd.ready) begin
        c.opcode       = opcode_t'(cmd.opcode);
        c.direction    = dir_t'(cmd.direction);
        c.stride       = cmd.stride;
        c.move_count   = cmd.move_count;
        c.user_request = cmd.user_request;
        c.right_limit  = cmd.right_limit;
        c.left_limit   = cmd.left_limit;
        advance_motor(c, want);
        motion_q.push_back(want);
      end
    end
    queued = motion_q.size();
  end

endmodule

`default_nettype wire

FILE: verif/tb.sv
// ----------------------------------------------------------------------------
// Stepper phase sequencer testbench
// Drives move and tick transactions with random gaps and result back-pressure,
// switches the homed register between phases, and reports the checker verdict.
// ----------------------------------------------------------------------------
`default_nettype none

module tb;
  import sps_pkg::*;

  logic                  clk;
  logic                  rst;
  logic                  psel;
  logic                  penable;
  logic                  pwrite;
  logic [PADDR_BITS-1:0] paddr;
  logic [31:0]           pwdata;
  logic [31:0]           prdata;
  logic                  pready;
  int                    errors;
  int                    pending;
  int                    sent = 0;
  logic                  quiet;
  int                    hold_requests;

  sps_cmd_if cmd_ch ();
  sps_res_if res_ch ();

  stepper_phase_sequencer_core dut (
    .clk     (clk),
    .rst     (rst),
    .cmd     (cmd_ch),
    .res     (res_ch),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  sps_motion_checker motion_chk (
    .clk     (clk),
    .rst     (rst),
    .cmd     (cmd_ch),
    .res     (res_ch),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .pready  (pready),
    .errors  (errors),
    .pending (pending)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  initial begin
    #(12 * 300000);
    $display("DONE: errors detected");
    $finish;
  end

  initial begin : result_side
    int served;
    served = 0;
    res_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_requests > served) begin
        served++;
        res_ch.ready <= 1'b0;
        repeat (90) @(posedge clk);
      end else begin
        res_ch.ready <= quiet || ($urandom_range(99) >= 22);
      end
    end
  end

  function automatic cmd_t random_item();
    cmd_t c;
    c.opcode       = opcode_t'($urandom_range(1));
    c.direction    = dir_t'($urandom_range(1));
    c.stride       = 2'($urandom_range(3));
    c.move_count   = 16'($urandom_range(16'hFFFF));
    c.user_request = 1'($urandom_range(1));
    c.right_limit  = 1'($urandom_range(1));
    c.left_limit   = 1'($urandom_range(1));
    return c;
  endfunction

  function automatic cmd_t move_cmd(dir_t d, logic [1:0] sz, logic [15:0] n, logic usr,
                                    logic rl, logic ll);
    cmd_t c;
    c.opcode       = OP_MOVE;
    c.direction    = d;
    c.stride       = sz;
    c.move_count   = n;
    c.user_request = usr;
    c.right_limit  = rl;
    c.left_limit   = ll;
    return c;
  endfunction

  function automatic cmd_t tick_cmd(logic rl, logic ll);
    cmd_t c;
    c             = random_item();
    c.opcode      = OP_TICK;
    c.right_limit = rl;
    c.left_limit  = ll;
    return c;
  endfunction

  function automatic cmd_t random_move();
    cmd_t c;
    int   roll;
    c        = random_item();
    c.opcode = OP_MOVE;
    if ($urandom_range(9) == 0) c.stride = 2'($urandom_range(3));
    else c.stride = 2'($urandom_range(1, 2));
    roll = $urandom_range(99);
    if (roll < 10) c.move_count = 16'($urandom_range(16'hFFFF));
    else if (roll < 15) c.move_count = '0;
    else c.move_count = 16'($urandom_range(1, 10));
    c.right_limit = ($urandom_range(99) < 8);
    c.left_limit  = ($urandom_range(99) < 8);
    return c;
  endfunction

  task automatic push_item(input cmd_t c);
    if (!quiet && $urandom_range(99) < 22) begin
      cmd_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 2)) @(posedge clk);
    end
    cmd_ch.valid        <= 1'b1;
    cmd_ch.opcode       <= c.opcode;
    cmd_ch.direction    <= c.direction;
    cmd_ch.stride       <= c.stride;
    cmd_ch.move_count   <= c.move_count;
    cmd_ch.user_request <= c.user_request;
    cmd_ch.right_limit  <= c.right_limit;
    cmd_ch.left_limit   <= c.left_limit;
    @(posedge clk);
    while (!cmd_ch.ready) @(posedge clk);
    sent++;
  endtask

  task automatic settle();
    int guard;
    guard = 0;
    cmd_ch.valid <= 1'b0;
    @(posedge clk);
    while (pending != 0 && guard < 2000) begin
      @(posedge clk);
      guard++;
    end
    repeat (4) @(posedge clk);
  endtask

  task automatic set_homed(input logic v);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {REG_HOMED, 2'b00};
    pwdata  <= {31'b0, v};
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  task automatic run_random(input int n_items);
    int done;
    int k;
    done = 0;
    while (done < n_items) begin
      if ($urandom_range(99) < 75) begin
        push_item(random_move());
        done++;
        k = $urandom_range(0, 12);
        repeat (k) begin
          push_item(tick_cmd($urandom_range(99) < 5, $urandom_range(99) < 5));
          done++;
        end
      end else begin
        push_item(random_item());
        done++;
      end
    end
  endtask

  initial begin : stimulus
    rst                 <= 1'b1;
    quiet               <= 1'b0;
    hold_requests       <= 0;
    psel                <= 1'b0;
    penable             <= 1'b0;
    pwrite              <= 1'b0;
    paddr               <= '0;
    pwdata              <= '0;
    cmd_ch.valid        <= 1'b0;
    cmd_ch.opcode       <= OP_TICK;
    cmd_ch.direction    <= TRAVEL_RIGHT;
    cmd_ch.stride       <= '0;
    cmd_ch.move_count   <= '0;
    cmd_ch.user_request <= 1'b0;
    cmd_ch.right_limit  <= 1'b0;
    cmd_ch.left_limit   <= 1'b0;
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    set_homed(1'b1);
    push_item(tick_cmd(1'b0, 1'b0));
    push_item(move_cmd(TRAVEL_RIGHT, 2'd1, 16'd3, 1'b1, 1'b0, 1'b0));
    repeat (4) push_item(tick_cmd(1'b0, 1'b0));
    push_item(move_cmd(TRAVEL_LEFT, 2'd2, 16'd4, 1'b0, 1'b0, 1'b0));
    push_item(tick_cmd(1'b1, 1'b0));
    push_item(tick_cmd(1'b0, 1'b0));
    push_item(tick_cmd(1'b0, 1'b1));
    push_item(tick_cmd(1'b0, 1'b0));
    push_item(move_cmd(TRAVEL_RIGHT, 2'd2, 16'd5, 1'b1, 1'b1, 1'b0));
    push_item(move_cmd(TRAVEL_LEFT, 2'd1, 16'd5, 1'b0, 1'b1, 1'b1));
    push_item(move_cmd(TRAVEL_RIGHT, 2'd1, 16'd0, 1'b1, 1'b0, 1'b0));
    push_item(tick_cmd(1'b0, 1'b0));
    push_item(move_cmd(TRAVEL_RIGHT, 2'd0, 16'd2, 1'b0, 1'b0, 1'b1));
    repeat (2) push_item(tick_cmd(1'b0, 1'b0));
    push_item(move_cmd(TRAVEL_LEFT, 2'd3, 16'd2, 1'b1, 1'b1, 1'b0));
    repeat (2) push_item(tick_cmd(1'b0, 1'b0));
    push_item(move_cmd(TRAVEL_RIGHT, 2'd1, 16'hFFFF, 1'b1, 1'b0, 1'b1));
    repeat (2) push_item(tick_cmd(1'b0, 1'b1));
    push_item(move_cmd(TRAVEL_LEFT, 2'd2, 16'd0, 1'b0, 1'b0, 1'b0));
    settle();

    set_homed(1'b0);
    push_item(move_cmd(TRAVEL_RIGHT, 2'd1, 16'd3, 1'b1, 1'b0, 1'b0));
    push_item(tick_cmd(1'b0, 1'b0));
    push_item(move_cmd(TRAVEL_LEFT, 2'd1, 16'd2, 1'b0, 1'b0, 1'b0));
    repeat (2) push_item(tick_cmd(1'b0, 1'b0));
    settle();

    for (int ph = 0; ph < 6; ph++) begin
      set_homed((ph == 2 || ph == 4) ? 1'b0 : 1'b1);
      if (ph == 1) hold_requests <= hold_requests + 1;
      quiet <= (ph == 3);
      run_random(70);
      settle();
    end
    quiet <= 1'b0;
    settle();

    $display("Ran %0d move and tick transactions with homed set and cleared,", sent);
    $display("covering limit stops, zero counts, odd step sizes and result back-pressure.");
    if (errors == 0 && pending == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

`default_nettype wire

FILE: stepper_phase_sequencer_core.f
+incdir+src
src/sps_pkg.sv
src/sps_if.sv
src/sps_apb_regs.sv
src/sps_in_reg.sv
src/sps_step_logic.sv
src/sps_out_reg.sv
src/stepper_phase_sequencer_core.sv
verif/sps_motion_checker.sv
verif/tb.sv
